// ----- src/assert_macros.svh -----
// Assertion macros for the ramped gain matrix mixer.
// Users must have clk and arst_n in scope; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("Same-cycle implication check failed.");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("Next-cycle implication check failed.");

`endif

// ----- src/rgmm_pkg.sv -----
// Shared constants, types and helper functions for the ramped gain matrix mixer.
// Used by rgmm_lane, rgmm_merge and the top level; depends on nothing.
`default_nettype none

package rgmm_pkg;

	localparam int CHANNELS      = 8;
	localparam int OUT_CHANNELS  = 8;
	localparam int MAX_BLOCK     = 4096;

	localparam int SAMPLE_FIELDS = 8;
	localparam int OUT_FIELDS    = 8;
	localparam int ROWS  = (CHANNELS < SAMPLE_FIELDS) ? CHANNELS : SAMPLE_FIELDS;
	localparam int LANES = (OUT_CHANNELS < OUT_FIELDS) ? OUT_CHANNELS : OUT_FIELDS;

	localparam int GW        = 17;
	localparam int SAMPLE_W  = 24;
	localparam int OUT_W     = 24;
	localparam int FRAC_W    = 16;
	localparam int SRC_W     = 4;
	localparam int BLEN_W    = 13;
	localparam int CH_SEL_W  = 3;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DATA_W = 13;

	localparam int IDX_W     = $clog2(MAX_BLOCK);
	localparam int LEN_W     = $clog2(MAX_BLOCK + 1);
	localparam int NUM_W     = GW + IDX_W;
	localparam int ROW_W     = $clog2(ROWS);
	localparam int CNT_W     = $clog2(ROWS + 1);
	localparam int DIV_CNT_W = $clog2(GW);
	localparam int PROD_W    = SAMPLE_W + GW;
	localparam int ACC_W     = PROD_W + $clog2(ROWS);
	localparam int SH_W      = ACC_W - FRAC_W;

	localparam logic [SRC_W-1:0]  SRC_RESET  = SRC_W'(2);
	localparam logic [BLEN_W-1:0] BLEN_RESET = BLEN_W'(256);

	localparam logic signed [OUT_W-1:0] SAT_HI = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic signed [OUT_W-1:0] SAT_LO = {1'b1, {(OUT_W-1){1'b0}}};

	localparam logic CMD_GAIN  = 1'b0;
	localparam logic CMD_FRAME = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_SRC_CHANNELS = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LENGTH = CFG_IDX_W'(1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIFF,
		ST_MUL,
		ST_DIV,
		ST_GAIN,
		ST_PROD,
		ST_ACC,
		ST_DONE
	} state_t;

	typedef struct packed {
		state_t            st;
		logic [ROW_W-1:0]  row;
		logic              clear;
		logic              commit;
	} lane_ctrl_t;

	typedef struct packed {
		logic              en;
		logic [ROW_W-1:0]  row;
		logic [GW-1:0]     value;
	} gain_wr_t;

	function automatic logic [LEN_W-1:0] clamp_len(input logic [BLEN_W-1:0] bl);
		int unsigned v;
		v = 32'(bl);
		if (v == 0)
			v = 1;
		if (v > MAX_BLOCK)
			v = MAX_BLOCK;
		return LEN_W'(v);
	endfunction

	// Floor shift by the gain fraction, then clamp to the output range.
	function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [ACC_W-1:0] a);
		logic signed [SH_W-1:0] sh;
		sh = $signed(a[ACC_W-1:FRAC_W]);
		if (sh > SH_W'(SAT_HI))
			return SAT_HI;
		if (sh < SH_W'(SAT_LO))
			return SAT_LO;
		return sh[OUT_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ----- src/rgmm_lane.sv -----
// One output-channel lane: holds its column of start and target gains,
// ramps each gain with a shared-step restoring divider and accumulates the mix.
// Depends on rgmm_pkg.
`default_nettype none

module rgmm_lane (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire rgmm_pkg::lane_ctrl_t                ctrl,
	input  wire rgmm_pkg::gain_wr_t                  wr,
	input  wire logic [rgmm_pkg::IDX_W-1:0]          idx,
	input  wire logic [rgmm_pkg::LEN_W-1:0]          len,
	input  wire logic signed [rgmm_pkg::SAMPLE_W-1:0] sample,
	output logic signed [rgmm_pkg::ACC_W-1:0]        acc
);

	logic [rgmm_pkg::GW-1:0] target_q [rgmm_pkg::ROWS];
	logic [rgmm_pkg::GW-1:0] start_q  [rgmm_pkg::ROWS];

	logic [rgmm_pkg::GW-1:0]        s_q;
	logic [rgmm_pkg::GW-1:0]        mag_q;
	logic                           neg_q;
	logic [rgmm_pkg::LEN_W-1:0]     rem_q;
	logic [rgmm_pkg::GW-1:0]        qsh_q;
	logic [rgmm_pkg::GW-1:0]        g_q;
	logic signed [rgmm_pkg::PROD_W-1:0] prod_q;
	logic signed [rgmm_pkg::ACC_W-1:0]  acc_q;

	logic [rgmm_pkg::GW:0]          diff;
	logic [rgmm_pkg::GW-1:0]        mag;
	logic [rgmm_pkg::NUM_W-1:0]     num;
	logic [rgmm_pkg::LEN_W:0]       trial;
	logic                           fits;
	logic signed [rgmm_pkg::PROD_W:0] prod_full;

	always_comb begin
		diff = {1'b0, target_q[ctrl.row]} - {1'b0, start_q[ctrl.row]};
		mag = diff[rgmm_pkg::GW] ? rgmm_pkg::GW'(-diff) : diff[rgmm_pkg::GW-1:0];
		num = rgmm_pkg::NUM_W'(mag_q) * rgmm_pkg::NUM_W'(idx);
		trial = {rem_q, qsh_q[rgmm_pkg::GW-1]};
		fits = (trial >= {1'b0, len});
		prod_full = sample * $signed({1'b0, g_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < rgmm_pkg::ROWS; r++) begin
				target_q[r] <= '0;
				start_q[r] <= '0;
			end
		end else begin
			if (wr.en)
				target_q[wr.row] <= wr.value;
			if (ctrl.commit) begin
				for (int r = 0; r < rgmm_pkg::ROWS; r++)
					start_q[r] <= target_q[r];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.clear)
			acc_q <= '0;
		case (ctrl.st)
			rgmm_pkg::ST_DIFF: begin
				s_q <= start_q[ctrl.row];
				mag_q <= mag;
				neg_q <= diff[rgmm_pkg::GW];
			end
			rgmm_pkg::ST_MUL: begin
				rem_q <= rgmm_pkg::LEN_W'(num[rgmm_pkg::NUM_W-1:rgmm_pkg::GW]);
				qsh_q <= num[rgmm_pkg::GW-1:0];
			end
			rgmm_pkg::ST_DIV: begin
				rem_q <= fits ? rgmm_pkg::LEN_W'(trial - {1'b0, len})
					: trial[rgmm_pkg::LEN_W-1:0];
				qsh_q <= {qsh_q[rgmm_pkg::GW-2:0], fits};
			end
			rgmm_pkg::ST_GAIN: begin
				g_q <= neg_q ? (s_q - qsh_q) : (s_q + qsh_q);
			end
			rgmm_pkg::ST_PROD: begin
				prod_q <= prod_full[rgmm_pkg::PROD_W-1:0];
			end
			rgmm_pkg::ST_ACC: begin
				acc_q <= acc_q + rgmm_pkg::ACC_W'(prod_q);
			end
			default: begin
			end
		endcase
	end

	assign acc = acc_q;

endmodule

`default_nettype wire

// ----- src/rgmm_merge.sv -----
// Merging stage: scales and saturates every lane's sum and holds the result
// item in the output register until it is taken. Depends on rgmm_pkg.
`default_nettype none

module rgmm_merge (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              load,
	input  wire logic signed [rgmm_pkg::ACC_W-1:0] acc [rgmm_pkg::LANES],
	input  wire logic                              out_ready,
	output logic                                   out_valid,
	output logic                                   free,
	output logic signed [rgmm_pkg::OUT_W-1:0]      result [rgmm_pkg::OUT_FIELDS]
);

	logic signed [rgmm_pkg::OUT_W-1:0] sat_val  [rgmm_pkg::OUT_FIELDS];
	logic signed [rgmm_pkg::OUT_W-1:0] result_q [rgmm_pkg::OUT_FIELDS];
	logic                              valid_q;

	for (genvar j = 0; j < rgmm_pkg::OUT_FIELDS; j++) begin : g_sat
		if (j < rgmm_pkg::LANES) begin : g_used
			assign sat_val[j] = rgmm_pkg::sat_out(acc[j]);
		end else begin : g_unused
			assign sat_val[j] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int j = 0; j < rgmm_pkg::OUT_FIELDS; j++)
				result_q[j] <= sat_val[j];
		end
	end

	assign out_valid = valid_q;
	assign free = !valid_q || out_ready;
	assign result = result_q;

endmodule

`default_nettype wire

// ----- src/ramped_gain_matrix_mixer_top.sv -----
// Gains and frames are accepted only in idle. A frame with N active input channels runs
// the DIFF, MUL, DIV, GAIN, PROD and ACC states per row, DIV being the 17-step ramp
// divider each lane runs per row; no new item is taken until the result is loaded.
// The output register lets gain writes proceed while a result waits to be taken.
// Reset clears all gains and the frame index at once and restores the register defaults.
// Depends on rgmm_pkg, rgmm_lane, rgmm_merge and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ramped_gain_matrix_mixer_top (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic                                 command,
	input  wire logic [rgmm_pkg::CH_SEL_W-1:0]        gain_in_channel,
	input  wire logic [rgmm_pkg::CH_SEL_W-1:0]        gain_out_channel,
	input  wire logic [rgmm_pkg::GW-1:0]              gain_value,
	input  wire logic signed [rgmm_pkg::SAMPLE_W-1:0] sample_0,
	input  wire logic signed [rgmm_pkg::SAMPLE_W-1:0] sample_1,
	input  wire logic signed [rgmm_pkg::SAMPLE_W-1:0] sample_2,
	input  wire logic signed [rgmm_pkg::SAMPLE_W-1:0] sample_3,
	input  wire logic signed [rgmm_pkg::SAMPLE_W-1:0] sample_4,
	input  wire logic signed [rgmm_pkg::SAMPLE_W-1:0] sample_5,
	input  wire logic signed [rgmm_pkg::SAMPLE_W-1:0] sample_6,
	input  wire logic signed [rgmm_pkg::SAMPLE_W-1:0] sample_7,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic signed [rgmm_pkg::OUT_W-1:0]         out_0,
	output logic signed [rgmm_pkg::OUT_W-1:0]         out_1,
	output logic signed [rgmm_pkg::OUT_W-1:0]         out_2,
	output logic signed [rgmm_pkg::OUT_W-1:0]         out_3,
	output logic signed [rgmm_pkg::OUT_W-1:0]         out_4,
	output logic signed [rgmm_pkg::OUT_W-1:0]         out_5,
	output logic signed [rgmm_pkg::OUT_W-1:0]         out_6,
	output logic signed [rgmm_pkg::OUT_W-1:0]         out_7,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [rgmm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [rgmm_pkg::CFG_DATA_W-1:0]      cfg_data
);

	rgmm_pkg::state_t state_q, state_d;

	logic [rgmm_pkg::SRC_W-1:0]     src_q;
	logic [rgmm_pkg::BLEN_W-1:0]    blen_q;
	logic [rgmm_pkg::IDX_W-1:0]     frame_q;
	logic [rgmm_pkg::ROW_W-1:0]     row_q;
	logic [rgmm_pkg::DIV_CNT_W-1:0] div_cnt_q;
	logic [rgmm_pkg::IDX_W-1:0]     idx_q;
	logic [rgmm_pkg::LEN_W-1:0]     len_q;
	logic [rgmm_pkg::CNT_W-1:0]     active_q;
	logic signed [rgmm_pkg::SAMPLE_W-1:0] samples_q [rgmm_pkg::ROWS];

	logic signed [rgmm_pkg::SAMPLE_W-1:0] sample_in [rgmm_pkg::SAMPLE_FIELDS];
	logic signed [rgmm_pkg::ACC_W-1:0]    lane_acc  [rgmm_pkg::LANES];
	logic signed [rgmm_pkg::OUT_W-1:0]    result    [rgmm_pkg::OUT_FIELDS];
	rgmm_pkg::gain_wr_t                   lane_wr   [rgmm_pkg::LANES];
	rgmm_pkg::lane_ctrl_t                 ctrl;

	logic                           in_acc;
	logic                           frame_acc;
	logic                           gain_acc;
	logic                           row_ok;
	logic                           col_ok;
	logic                           last_row;
	logic                           load;
	logic                           free;
	logic [rgmm_pkg::LEN_W-1:0]     len_now;
	logic [rgmm_pkg::LEN_W-1:0]     len_m1;
	logic [rgmm_pkg::IDX_W-1:0]     idx_now;
	logic [rgmm_pkg::CNT_W-1:0]     active_now;

	assign sample_in[0] = sample_0;
	assign sample_in[1] = sample_1;
	assign sample_in[2] = sample_2;
	assign sample_in[3] = sample_3;
	assign sample_in[4] = sample_4;
	assign sample_in[5] = sample_5;
	assign sample_in[6] = sample_6;
	assign sample_in[7] = sample_7;

	assign cfg_ready = 1'b1;

	always_comb begin
		in_acc = in_valid && in_ready;
		frame_acc = in_acc && (command == rgmm_pkg::CMD_FRAME);
		gain_acc = in_acc && (command == rgmm_pkg::CMD_GAIN);
		row_ok = ({1'b0, gain_in_channel} < 4'(rgmm_pkg::ROWS));
		col_ok = ({1'b0, gain_out_channel} < 4'(rgmm_pkg::LANES));
		len_now = rgmm_pkg::clamp_len(blen_q);
		len_m1 = len_now - rgmm_pkg::LEN_W'(1);
		idx_now = (rgmm_pkg::LEN_W'(frame_q) > len_m1) ? rgmm_pkg::IDX_W'(len_m1) : frame_q;
		active_now = (src_q > rgmm_pkg::SRC_W'(rgmm_pkg::ROWS))
			? rgmm_pkg::CNT_W'(rgmm_pkg::ROWS) : rgmm_pkg::CNT_W'(src_q);
		last_row = (row_q == rgmm_pkg::ROW_W'(active_q - rgmm_pkg::CNT_W'(1)));
	end

	// The block ends after a frame whose index plus one reaches the length.
	logic [rgmm_pkg::LEN_W:0] frame_next;
	assign frame_next = {1'b0, rgmm_pkg::LEN_W'(frame_q)} + {{rgmm_pkg::LEN_W{1'b0}}, 1'b1};

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		load = 1'b0;
		case (state_q)
			rgmm_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && command == rgmm_pkg::CMD_FRAME)
					state_d = (active_now == '0) ? rgmm_pkg::ST_DONE : rgmm_pkg::ST_DIFF;
			end
			rgmm_pkg::ST_DIFF: state_d = rgmm_pkg::ST_MUL;
			rgmm_pkg::ST_MUL:  state_d = rgmm_pkg::ST_DIV;
			rgmm_pkg::ST_DIV: begin
				if (div_cnt_q == rgmm_pkg::DIV_CNT_W'(rgmm_pkg::GW - 1))
					state_d = rgmm_pkg::ST_GAIN;
			end
			rgmm_pkg::ST_GAIN: state_d = rgmm_pkg::ST_PROD;
			rgmm_pkg::ST_PROD: state_d = rgmm_pkg::ST_ACC;
			rgmm_pkg::ST_ACC:  state_d = last_row ? rgmm_pkg::ST_DONE : rgmm_pkg::ST_DIFF;
			rgmm_pkg::ST_DONE: begin
				if (free) begin
					load = 1'b1;
					state_d = rgmm_pkg::ST_IDLE;
				end
			end
			default: state_d = rgmm_pkg::ST_IDLE;
		endcase
		ctrl.st = state_q;
		ctrl.row = row_q;
		ctrl.clear = frame_acc;
		ctrl.commit = load && (frame_next >= {1'b0, len_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= rgmm_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q <= rgmm_pkg::SRC_RESET;
			blen_q <= rgmm_pkg::BLEN_RESET;
			frame_q <= '0;
			row_q <= '0;
			div_cnt_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					rgmm_pkg::CFG_SRC_CHANNELS: src_q <= cfg_data[rgmm_pkg::SRC_W-1:0];
					rgmm_pkg::CFG_BLOCK_LENGTH: blen_q <= cfg_data[rgmm_pkg::BLEN_W-1:0];
					default: begin
					end
				endcase
			end
			if (frame_acc)
				row_q <= '0;
			else if (state_q == rgmm_pkg::ST_ACC && !last_row)
				row_q <= row_q + rgmm_pkg::ROW_W'(1);
			if (state_q == rgmm_pkg::ST_MUL)
				div_cnt_q <= '0;
			else if (state_q == rgmm_pkg::ST_DIV)
				div_cnt_q <= div_cnt_q + rgmm_pkg::DIV_CNT_W'(1);
			if (ctrl.commit)
				frame_q <= '0;
			else if (load)
				frame_q <= frame_q + rgmm_pkg::IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (frame_acc) begin
			idx_q <= idx_now;
			len_q <= len_now;
			active_q <= active_now;
			for (int r = 0; r < rgmm_pkg::ROWS; r++)
				samples_q[r] <= sample_in[r];
		end
	end

	for (genvar j = 0; j < rgmm_pkg::LANES; j++) begin : g_lane
		assign lane_wr[j].en = gain_acc && row_ok && col_ok
			&& (gain_out_channel == rgmm_pkg::CH_SEL_W'(j));
		assign lane_wr[j].row = gain_in_channel[rgmm_pkg::ROW_W-1:0];
		assign lane_wr[j].value = gain_value;

		rgmm_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.wr     (lane_wr[j]),
			.idx    (idx_q),
			.len    (len_q),
			.sample (samples_q[row_q]),
			.acc    (lane_acc[j])
		);
	end

	rgmm_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.acc       (lane_acc),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.free      (free),
		.result    (result)
	);

	assign out_0 = result[0];
	assign out_1 = result[1];
	assign out_2 = result[2];
	assign out_3 = result[3];
	assign out_4 = result[4];
	assign out_5 = result[5];
	assign out_6 = result[6];
	assign out_7 = result[7];

	`ASSERT_IMPLIES(a_no_overwrite, load, !out_valid || out_ready)
	`ASSERT_NEXT(a_frame_starts, frame_acc,
		state_q == rgmm_pkg::ST_DIFF || state_q == rgmm_pkg::ST_DONE)
	`ASSERT_NEXT(a_gain_stays_idle, gain_acc, state_q == rgmm_pkg::ST_IDLE)
	`ASSERT_NEXT(a_div_holds,
		state_q == rgmm_pkg::ST_DIV && div_cnt_q != rgmm_pkg::DIV_CNT_W'(rgmm_pkg::GW - 1),
		state_q == rgmm_pkg::ST_DIV)

endmodule

`default_nettype wire

// ----- sim/ramped_gain_matrix_mixer_top_test.sv -----
// Self-checking testbench for ramped_gain_matrix_mixer_top, with its own predictor of the
// gain ramp and the saturated mix. Depends on rgmm_pkg and the mixer RTL only.
`timescale 1ns / 100ps

module ramped_gain_matrix_mixer_top_test;
	import rgmm_pkg::*;

	typedef struct packed {
		logic                                   cmd;
		logic [CH_SEL_W-1:0]                    row;
		logic [CH_SEL_W-1:0]                    col;
		logic [GW-1:0]                          gain;
		logic [SAMPLE_FIELDS-1:0][SAMPLE_W-1:0] smp;
	} mix_item_t;

	typedef logic [OUT_FIELDS-1:0][OUT_W-1:0] mix_out_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic command;
	logic [CH_SEL_W-1:0] gain_in_channel;
	logic [CH_SEL_W-1:0] gain_out_channel;
	logic [GW-1:0] gain_value;
	logic signed [SAMPLE_W-1:0] sample_0, sample_1, sample_2, sample_3;
	logic signed [SAMPLE_W-1:0] sample_4, sample_5, sample_6, sample_7;
	logic out_valid;
	logic out_ready;
	logic signed [OUT_W-1:0] out_0, out_1, out_2, out_3, out_4, out_5, out_6, out_7;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	logic [GW-1:0] gain_target [CHANNELS][OUT_CHANNELS];
	logic [GW-1:0] gain_start [CHANNELS][OUT_CHANNELS];
	int unsigned ramp_pos;
	logic [SRC_W-1:0] model_src;
	logic [BLEN_W-1:0] model_blen;

	mix_out_t expected_mix_q[$];
	int err_count = 0;
	int shown = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_left = 0;

	ramped_gain_matrix_mixer_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .gain_in_channel(gain_in_channel),
		.gain_out_channel(gain_out_channel), .gain_value(gain_value),
		.sample_0(sample_0), .sample_1(sample_1), .sample_2(sample_2), .sample_3(sample_3),
		.sample_4(sample_4), .sample_5(sample_5), .sample_6(sample_6), .sample_7(sample_7),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_0(out_0), .out_1(out_1), .out_2(out_2), .out_3(out_3),
		.out_4(out_4), .out_5(out_5), .out_6(out_6), .out_7(out_7),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#30000000;
		$display("TB_ERROR");
		$finish;
	end

	// Updates the gain matrix on a gain write, or mixes one frame and advances the ramp.
	task automatic apply_item(input mix_item_t it);
		int unsigned len, idx, act;
		int i, j;
		longint acc, g, s0, t0, y;
		mix_out_t res;
		if (it.cmd == CMD_GAIN) begin
			gain_target[it.row][it.col] = it.gain;
			return;
		end
		len = model_blen;
		if (len == 0)
			len = 1;
		if (len > MAX_BLOCK)
			len = MAX_BLOCK;
		idx = (ramp_pos > len - 1) ? len - 1 : ramp_pos;
		act = model_src;
		if (act > CHANNELS)
			act = CHANNELS;
		if (act > SAMPLE_FIELDS)
			act = SAMPLE_FIELDS;
		for (j = 0; j < OUT_FIELDS; j++) begin
			acc = 0;
			if (j < OUT_CHANNELS) begin
				for (i = 0; i < act; i++) begin
					s0 = longint'(gain_start[i][j]);
					t0 = longint'(gain_target[i][j]);
					g = s0 + ((t0 - s0) * longint'(idx)) / longint'(len);
					acc += longint'($signed(it.smp[i])) * g;
				end
			end
			y = acc >>> FRAC_W;
			if (y > longint'(SAT_HI))
				y = longint'(SAT_HI);
			if (y < longint'(SAT_LO))
				y = longint'(SAT_LO);
			res[j] = y[OUT_W-1:0];
		end
		expected_mix_q.push_back(res);
		if (ramp_pos + 1 >= len) begin
			gain_start = gain_target;
			ramp_pos = 0;
		end else begin
			ramp_pos++;
		end
	endtask

	function automatic mix_item_t gain_item(input int row, input int col,
			input logic [GW-1:0] val);
		mix_item_t it;
		it = '0;
		it.cmd = CMD_GAIN;
		it.row = CH_SEL_W'(row);
		it.col = CH_SEL_W'(col);
		it.gain = val;
		return it;
	endfunction

	function automatic mix_item_t flat_frame(input logic [SAMPLE_W-1:0] s);
		mix_item_t it;
		int i;
		it = '0;
		it.cmd = CMD_FRAME;
		for (i = 0; i < SAMPLE_FIELDS; i++)
			it.smp[i] = s;
		return it;
	endfunction

	function automatic logic [SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(7))
			0: return SAT_HI;
			1: return SAT_LO;
			2: return '0;
			3: return '1;
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	function automatic mix_item_t rand_frame();
		mix_item_t it;
		int i;
		it = '0;
		it.cmd = CMD_FRAME;
		it.row = CH_SEL_W'($urandom);
		it.col = CH_SEL_W'($urandom);
		it.gain = GW'($urandom);
		for (i = 0; i < SAMPLE_FIELDS; i++)
			it.smp[i] = rand_sample();
		return it;
	endfunction

	function automatic mix_item_t rand_gain_write();
		mix_item_t it;
		it = rand_frame();
		it.cmd = CMD_GAIN;
		case ($urandom_range(7))
			0: it.gain = '0;
			1: it.gain = GW'(65536);
			2: it.gain = '1;
			default: it.gain = GW'($urandom_range(0, 131071));
		endcase
		return it;
	endfunction

	task automatic send_item(input mix_item_t it);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		command <= it.cmd;
		gain_in_channel <= it.row;
		gain_out_channel <= it.col;
		gain_value <= it.gain;
		sample_0 <= it.smp[0];
		sample_1 <= it.smp[1];
		sample_2 <= it.smp[2];
		sample_3 <= it.smp[3];
		sample_4 <= it.smp[4];
		sample_5 <= it.smp[5];
		sample_6 <= it.smp[6];
		sample_7 <= it.smp[7];
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		apply_item(it);
	endtask

	// Stops offering items and waits for every pending result, plus a margin
	// for a gain write that may still be in flight.
	task automatic settle();
		int guard;
		guard = 0;
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_mix_q.size() != 0 && guard < 200000) begin
			@(negedge clk);
			guard++;
		end
		repeat (30) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_SRC_CHANNELS)
			model_src = data[SRC_W-1:0];
		else if (idx == CFG_BLOCK_LENGTH)
			model_blen = data;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_reset_state();
		send_item(rand_frame());
		send_item(gain_item(0, 0, GW'(65536)));
		send_item(rand_frame());
		send_item(rand_frame());
	endtask

	task automatic test_extremes();
		settle();
		cfg_write(CFG_SRC_CHANNELS, CFG_DATA_W'(13'h1FF8));
		cfg_write(CFG_BLOCK_LENGTH, '0);
		send_item(gain_item(7, 7, '1));
		send_item(gain_item(0, 7, '1));
		send_item(gain_item(3, 0, GW'(1)));
		send_item(flat_frame(SAT_HI));
		send_item(flat_frame(SAT_HI));
		send_item(flat_frame(SAT_LO));
		send_item(flat_frame('1));
	endtask

	task automatic test_block_lengths();
		settle();
		cfg_write(CFG_SRC_CHANNELS, CFG_DATA_W'(15));
		cfg_write(CFG_BLOCK_LENGTH, '1);
		send_item(rand_frame());
		send_item(rand_frame());
		send_item(gain_item(5, 2, GW'(65536)));
		send_item(rand_frame());
		settle();
		cfg_write(CFG_BLOCK_LENGTH, CFG_DATA_W'(3));
		send_item(rand_frame());
		send_item(rand_frame());
		settle();
		cfg_write(CFG_BLOCK_LENGTH, CFG_DATA_W'(MAX_BLOCK));
		send_item(rand_frame());
	endtask

	function automatic logic [CFG_IDX_W-1:0] CFG_INDEX_SPARE_HI();
		return '1;
	endfunction

	task automatic test_channel_counts();
		settle();
		cfg_write(CFG_SRC_CHANNELS, '0);
		send_item(rand_frame());
		send_item(rand_frame());
		settle();
		cfg_write(CFG_INDEX_SPARE_HI(), '1);
		cfg_write(CFG_IDX_W'(2), CFG_DATA_W'($urandom));
		cfg_write(CFG_SRC_CHANNELS, CFG_DATA_W'(1));
		send_item(rand_frame());
	endtask

	task automatic test_output_stall();
		int k;
		settle();
		cfg_write(CFG_SRC_CHANNELS, CFG_DATA_W'(8));
		cfg_write(CFG_BLOCK_LENGTH, CFG_DATA_W'(5));
		send_idle_pct = 0;
		hold_left = 1500;
		for (k = 0; k < 10; k++)
			send_item(rand_frame());
		settle();
	endtask

	task automatic random_config();
		logic [SRC_W-1:0] src;
		int r;
		r = $urandom_range(15);
		if (r < 12)
			src = SRC_W'($urandom_range(1, 8));
		else if (r == 12)
			src = '0;
		else
			src = SRC_W'($urandom_range(9, 15));
		cfg_write(CFG_SRC_CHANNELS, {9'($urandom), src});
		r = $urandom_range(15);
		if (r < 11)
			cfg_write(CFG_BLOCK_LENGTH, CFG_DATA_W'($urandom_range(1, 12)));
		else if (r == 11)
			cfg_write(CFG_BLOCK_LENGTH, '0);
		else if (r == 12)
			cfg_write(CFG_BLOCK_LENGTH, CFG_DATA_W'(MAX_BLOCK));
		else if (r == 13)
			cfg_write(CFG_BLOCK_LENGTH, CFG_DATA_W'($urandom_range(4097, 8191)));
		else
			cfg_write(CFG_BLOCK_LENGTH, CFG_DATA_W'($urandom_range(13, 300)));
	endtask

	task automatic test_random_mix(input int total);
		int sent, p, k, seg;
		sent = 0;
		for (p = 0; p < 3; p++) begin
			send_idle_pct = (p == 0) ? 26 : (p == 1) ? 64 : 0;
			recv_idle_pct = (p == 0) ? 64 : (p == 1) ? 26 : 0;
			while (sent < total * (p + 1) / 3) begin
				settle();
				random_config();
				seg = $urandom_range(20, 70);
				for (k = 0; k < seg; k++) begin
					if ($urandom_range(3) == 0)
						send_item(rand_gain_write());
					else
						send_item(rand_frame());
					sent++;
				end
			end
		end
	endtask

	initial begin : result_check
		mix_out_t got, want;
		int j;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				got[0] = out_0;
				got[1] = out_1;
				got[2] = out_2;
				got[3] = out_3;
				got[4] = out_4;
				got[5] = out_5;
				got[6] = out_6;
				got[7] = out_7;
				if (expected_mix_q.size() == 0) begin
					err_count++;
					if (shown < 10) begin
						shown++;
						$display("Mix result with none expected at %0t.", $realtime);
					end
				end else begin
					want = expected_mix_q.pop_front();
					for (j = 0; j < OUT_FIELDS; j++) begin
						if (got[j] !== want[j]) begin
							err_count++;
							if (shown < 10) begin
								shown++;
								$display("out_%0d mismatch at %0t: expected %0d, got %0d.",
									j, $realtime, $signed(want[j]), $signed(got[j]));
							end
						end
					end
				end
			end
		end
	end

	initial begin : result_drain
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = CMD_GAIN;
		gain_in_channel = '0;
		gain_out_channel = '0;
		gain_value = '0;
		sample_0 = '0;
		sample_1 = '0;
		sample_2 = '0;
		sample_3 = '0;
		sample_4 = '0;
		sample_5 = '0;
		sample_6 = '0;
		sample_7 = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_SRC_CHANNELS;
		cfg_data = '0;
		foreach (gain_target[r, c]) begin
			gain_target[r][c] = '0;
			gain_start[r][c] = '0;
		end
		ramp_pos = 0;
		model_src = SRC_RESET;
		model_blen = BLEN_RESET;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_state();
		test_extremes();
		test_block_lengths();
		test_channel_counts();
		test_output_stall();
		test_random_mix(600);

		settle();
		repeat (200) @(posedge clk);
		err_count += expected_mix_q.size();
		if (err_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+src
src/rgmm_pkg.sv
src/rgmm_lane.sv
src/rgmm_merge.sv
src/ramped_gain_matrix_mixer_top.sv
sim/ramped_gain_matrix_mixer_top_test.sv
